// ===== hdl/pmai_pkg.sv =====
// Shared types and constants of the sorted gapped slot array insert core.
// Command and status structs between controller and datapath, engine op and region codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pmai_pkg;

  localparam int unsigned RETRY_LIMIT = 64;
  localparam int unsigned PASS_W      = $clog2(RETRY_LIMIT + 1);

  typedef logic [2:0] eng_op_t;
  localparam eng_op_t OP_NONE   = 3'd0;
  localparam eng_op_t OP_CLEAR  = 3'd1;
  localparam eng_op_t OP_SCAN   = 3'd2;
  localparam eng_op_t OP_GATHER = 3'd3;
  localparam eng_op_t OP_MERGE  = 3'd4;
  localparam eng_op_t OP_SPREAD = 3'd5;

  typedef logic [2:0] region_t;
  localparam region_t REG_FULL  = 3'd0;
  localparam region_t REG_SLOT  = 3'd1;
  localparam region_t REG_MID   = 3'd2;
  localparam region_t REG_CHUNK = 3'd3;
  localparam region_t REG_WIN   = 3'd4;
  localparam region_t REG_ALL   = 3'd5;

  localparam logic OPC_INSERT = 1'b0;
  localparam logic OPC_READ   = 1'b1;

  typedef struct packed {
    eng_op_t op;
    region_t region;
    logic    capture;
    logic    srch_init;
    logic    srch_step;
    logic    set_bound;
    logic    lvl_init;
    logic    lvl_inc;
    logic    cnt_inc;
    logic    cap_inc;
    logic    pass_clr;
    logic    pass_inc;
    logic    res_write;
    logic    res_drop;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic is_read;
    logic empty;
    logic srch_eq;
    logic room;
    logic lvl_over;
    logic dens_ok;
    logic cap_full;
    logic pass_max;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/pmai_ctrl.sv =====
// Controller state machine of the insert core: sequences clear, read, search, merge, rebalance, resize.
// Depends on pmai_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module pmai_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output pmai_pkg::cmd_t     cmd_o,
  input  wire pmai_pkg::sts_t sts_i
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_CLRW  = 5'd1;
  localparam logic [4:0] S_IDLE  = 5'd2;
  localparam logic [4:0] S_DISP  = 5'd3;
  localparam logic [4:0] S_RDW   = 5'd4;
  localparam logic [4:0] S_PASS  = 5'd5;
  localparam logic [4:0] S_SRCH  = 5'd6;
  localparam logic [4:0] S_SRCHW = 5'd7;
  localparam logic [4:0] S_CHK   = 5'd8;
  localparam logic [4:0] S_CHKW  = 5'd9;
  localparam logic [4:0] S_MG1   = 5'd10;
  localparam logic [4:0] S_MG2   = 5'd11;
  localparam logic [4:0] S_LVL   = 5'd12;
  localparam logic [4:0] S_LVLW  = 5'd13;
  localparam logic [4:0] S_SP1   = 5'd14;
  localparam logic [4:0] S_SP2   = 5'd15;
  localparam logic [4:0] S_RSZ   = 5'd16;
  localparam logic [4:0] S_RS1   = 5'd17;
  localparam logic [4:0] S_RS1B  = 5'd18;
  localparam logic [4:0] S_RS2   = 5'd19;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    cmd_o.op     = pmai_pkg::OP_NONE;
    cmd_o.region = pmai_pkg::REG_FULL;
    case (state_q)
      S_CLR: begin
        cmd_o.op = pmai_pkg::OP_CLEAR;
        state_d  = S_CLRW;
      end
      S_CLRW: begin
        if (sts_i.done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.is_read) begin
          cmd_o.op     = pmai_pkg::OP_SCAN;
          cmd_o.region = pmai_pkg::REG_SLOT;
          state_d      = S_RDW;
        end else begin
          cmd_o.pass_clr = 1'b1;
          state_d        = S_PASS;
        end
      end
      S_RDW: begin
        if (sts_i.done) begin
          cmd_o.res_write = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_PASS: begin
        if (sts_i.pass_max) begin
          cmd_o.res_write = 1'b1;
          cmd_o.res_drop  = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.srch_init = 1'b1;
          state_d         = sts_i.empty ? S_CHK : S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts_i.srch_eq) begin
          cmd_o.set_bound = 1'b1;
          state_d         = S_CHK;
        end else begin
          cmd_o.op     = pmai_pkg::OP_SCAN;
          cmd_o.region = pmai_pkg::REG_MID;
          state_d      = S_SRCHW;
        end
      end
      S_SRCHW: begin
        if (sts_i.done) begin
          cmd_o.srch_step = 1'b1;
          state_d         = S_SRCH;
        end
      end
      S_CHK: begin
        cmd_o.op     = pmai_pkg::OP_SCAN;
        cmd_o.region = pmai_pkg::REG_CHUNK;
        state_d      = S_CHKW;
      end
      S_CHKW: begin
        if (sts_i.done) begin
          if (sts_i.room) begin
            cmd_o.op     = pmai_pkg::OP_GATHER;
            cmd_o.region = pmai_pkg::REG_CHUNK;
            state_d      = S_MG1;
          end else begin
            cmd_o.lvl_init = 1'b1;
            state_d        = S_LVL;
          end
        end
      end
      S_MG1: begin
        if (sts_i.done) begin
          cmd_o.op     = pmai_pkg::OP_MERGE;
          cmd_o.region = pmai_pkg::REG_CHUNK;
          state_d      = S_MG2;
        end
      end
      S_MG2: begin
        if (sts_i.done) begin
          cmd_o.cnt_inc   = 1'b1;
          cmd_o.res_write = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_LVL: begin
        if (sts_i.lvl_over) begin
          state_d = S_RSZ;
        end else begin
          cmd_o.op     = pmai_pkg::OP_SCAN;
          cmd_o.region = pmai_pkg::REG_WIN;
          state_d      = S_LVLW;
        end
      end
      S_LVLW: begin
        if (sts_i.done) begin
          if (sts_i.dens_ok) begin
            cmd_o.op     = pmai_pkg::OP_GATHER;
            cmd_o.region = pmai_pkg::REG_WIN;
            state_d      = S_SP1;
          end else begin
            cmd_o.lvl_inc = 1'b1;
            state_d       = S_LVL;
          end
        end
      end
      S_SP1: begin
        if (sts_i.done) begin
          cmd_o.op     = pmai_pkg::OP_SPREAD;
          cmd_o.region = pmai_pkg::REG_WIN;
          state_d      = S_SP2;
        end
      end
      S_SP2: begin
        if (sts_i.done) begin
          cmd_o.pass_inc = 1'b1;
          state_d        = S_PASS;
        end
      end
      S_RSZ: begin
        if (sts_i.cap_full) begin
          cmd_o.res_write = 1'b1;
          cmd_o.res_drop  = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.op     = pmai_pkg::OP_GATHER;
          cmd_o.region = pmai_pkg::REG_ALL;
          state_d      = S_RS1;
        end
      end
      S_RS1: begin
        if (sts_i.done) begin
          cmd_o.cap_inc = 1'b1;
          state_d       = S_RS1B;
        end
      end
      S_RS1B: begin
        cmd_o.op     = pmai_pkg::OP_SPREAD;
        cmd_o.region = pmai_pkg::REG_ALL;
        state_d      = S_RS2;
      end
      S_RS2: begin
        if (sts_i.done) begin
          cmd_o.pass_inc = 1'b1;
          state_d        = S_PASS;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  // engine completion is only expected while waiting on it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.done |-> (state_q == S_CLRW || state_q == S_RDW || state_q == S_SRCHW ||
                    state_q == S_CHKW || state_q == S_MG1 || state_q == S_MG2 ||
                    state_q == S_LVLW || state_q == S_SP1 || state_q == S_SP2 ||
                    state_q == S_RS1 || state_q == S_RS2))
    else $error("engine done outside a wait state");

endmodule
`default_nettype wire

// ===== hdl/pmai_dp.sv =====
// Datapath of the insert core: slot and gather memories, sweep engine, search and level state.
// Depends on pmai_pkg; driven by pmai_ctrl through command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module pmai_dp #(
  parameter int unsigned MAX_CAPACITY     = 1024,
  parameter int unsigned INITIAL_CAPACITY = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pmai_pkg::cmd_t      cmd_i,
  output pmai_pkg::sts_t           sts_o,
  input  wire logic                opcode_i,
  input  wire logic signed [31:0]  value_i,
  input  wire logic [9:0]          slot_index_i,
  output logic                     done_o,
  output logic                     slot_occupied_o,
  output logic signed [31:0]       slot_value_o,
  output logic [10:0]              element_count_o,
  output logic [3:0]               capacity_exponent_o,
  output logic                     status_o
);

  localparam int unsigned AW = $clog2(MAX_CAPACITY);
  localparam int unsigned LW = $clog2(AW + 1);
  localparam int unsigned TW = LW + 1;
  localparam int unsigned EW = AW + 2;
  localparam int unsigned PW = AW + LW + 3;
  localparam int unsigned IW = AW + 11;
  localparam int unsigned INIT_RAW = $clog2(INITIAL_CAPACITY);
  localparam int unsigned INIT_LOG = (INIT_RAW < 1) ? 1 : INIT_RAW;
  localparam int unsigned PSW = pmai_pkg::PASS_W;

  // item and algorithm state
  logic                    op_q;
  logic signed [31:0]      v_q;
  logic [9:0]              idx_q;
  logic [LW-1:0]           cap_log_q;
  logic [AW:0]             count_q;
  logic [PSW-1:0]          pass_q;
  logic [AW-1:0]           lo_q, hi_q, bnd_q;
  logic [LW-1:0]           level_q;

  // sweep engine
  logic                    run_q, pv_q, done_q, ins_q, found_q;
  pmai_pkg::eng_op_t       eop_q;
  logic [AW-1:0]           base_q, pa_q;
  logic [AW:0]             len_q, ofs_q, n_q, gk_q, gk_d, cnt_q;
  logic [EW-1:0]           e_q;
  logic signed [31:0]      rv_q;

  // memories
  logic signed [31:0]      slot_val_mem [MAX_CAPACITY];
  logic                    slot_pr_mem  [MAX_CAPACITY];
  logic signed [31:0]      gbuf_mem     [MAX_CAPACITY];
  logic signed [31:0]      rd_val_q, g_q;
  logic                    rd_pr_q;

  // derived geometry
  logic [TW-1:0]           two_l, fl;
  logic [LW-1:0]           chunk_log;
  logic [LW:0]             wlog;
  logic [AW:0]             cap, chunk_len, win_len, bnd_full, mid_full;
  logic [AW-1:0]           mid, cmask, wmask;
  logic [PW-1:0]           lhs, rhs;

  always_comb begin
    fl = '0;
    for (int b = 0; b < TW; b++) begin
      if (two_l[b]) fl = TW'(b);
    end
  end

  assign two_l     = {cap_log_q, 1'b0};
  assign chunk_log = (fl > TW'(cap_log_q)) ? cap_log_q : fl[LW-1:0];
  assign cap       = (AW+1)'(1) << cap_log_q;
  assign chunk_len = (AW+1)'(1) << chunk_log;
  assign wlog      = (LW+1)'(chunk_log) + (LW+1)'(level_q);
  assign win_len   = (AW+1)'(1) << wlog;
  assign cmask     = AW'(~(chunk_len - (AW+1)'(1)));
  assign wmask     = AW'(~(win_len - (AW+1)'(1)));
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign mid_full  = (AW+1)'(mid) << chunk_log;
  assign bnd_full  = (AW+1)'(lo_q) << chunk_log;
  assign lhs       = PW'(cnt_q) * PW'(two_l);
  assign rhs       = PW'(two_l - TW'(level_q)) << wlog;

  // region select
  logic [AW-1:0] base_sel;
  logic [AW:0]   len_sel;
  always_comb begin
    base_sel = '0;
    len_sel  = cap;
    case (cmd_i.region)
      pmai_pkg::REG_FULL: begin
        len_sel = (AW+1)'(MAX_CAPACITY);
      end
      pmai_pkg::REG_SLOT: begin
        base_sel = AW'(idx_q);
        len_sel  = (AW+1)'(1);
      end
      pmai_pkg::REG_MID: begin
        base_sel = mid_full[AW-1:0];
        len_sel  = chunk_len;
      end
      pmai_pkg::REG_CHUNK: begin
        base_sel = bnd_q & cmask;
        len_sel  = chunk_len;
      end
      pmai_pkg::REG_WIN: begin
        base_sel = bnd_q & wmask;
        len_sel  = win_len;
      end
      pmai_pkg::REG_ALL: begin
        len_sel = cap;
      end
      default: begin
        len_sel = cap;
      end
    endcase
  end

  // engine step logic
  logic          start_eng, sweep_op, issue, fin, take, place, mg_step, sp_step;
  logic [AW-1:0] ra, wa;
  logic          we_pr, we_val, wd_pr;
  logic signed [31:0] wd_val;

  assign start_eng = (cmd_i.op != pmai_pkg::OP_NONE);
  assign sweep_op  = (eop_q == pmai_pkg::OP_SCAN) || (eop_q == pmai_pkg::OP_GATHER) ||
                     (eop_q == pmai_pkg::OP_CLEAR);
  assign issue     = run_q && sweep_op && (ofs_q < len_q);
  assign ra        = base_q + ofs_q[AW-1:0];
  assign take      = !ins_q && ((gk_q == n_q) || (g_q >= v_q));
  assign place     = (e_q < EW'(n_q));

  always_comb begin
    case (eop_q)
      pmai_pkg::OP_SCAN, pmai_pkg::OP_GATHER, pmai_pkg::OP_CLEAR: fin = !(ofs_q < len_q) && !pv_q;
      pmai_pkg::OP_MERGE:  fin = (ofs_q > n_q);
      pmai_pkg::OP_SPREAD: fin = (gk_q == n_q);
      default:             fin = 1'b1;
    endcase
  end

  assign mg_step = run_q && (eop_q == pmai_pkg::OP_MERGE) && !fin;
  assign sp_step = run_q && (eop_q == pmai_pkg::OP_SPREAD) && !fin;

  always_comb begin
    gk_d = gk_q;
    if (start_eng) begin
      gk_d = '0;
    end else if ((mg_step && !take) || (sp_step && place)) begin
      gk_d = gk_q + (AW+1)'(1);
    end
  end

  always_comb begin
    we_pr  = 1'b0;
    we_val = 1'b0;
    wa     = ra;
    wd_pr  = 1'b0;
    wd_val = g_q;
    if (issue && (eop_q == pmai_pkg::OP_CLEAR)) begin
      we_pr = 1'b1;
    end else if (pv_q && rd_pr_q && (eop_q == pmai_pkg::OP_GATHER)) begin
      we_pr = 1'b1;
      wa    = pa_q;
    end else if (mg_step) begin
      we_pr  = 1'b1;
      we_val = 1'b1;
      wd_pr  = 1'b1;
      wd_val = take ? v_q : g_q;
    end else if (sp_step && place) begin
      we_pr  = 1'b1;
      we_val = 1'b1;
      wd_pr  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_pr) slot_pr_mem[wa] <= wd_pr;
    if (we_val) slot_val_mem[wa] <= wd_val;
    rd_pr_q  <= slot_pr_mem[ra];
    rd_val_q <= slot_val_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (pv_q && rd_pr_q && (eop_q == pmai_pkg::OP_GATHER)) begin
      gbuf_mem[n_q[AW-1:0]] <= rd_val_q;
    end
    g_q <= gbuf_mem[gk_d[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      eop_q  <= pmai_pkg::OP_NONE;
    end else begin
      done_q <= run_q && fin;
      pv_q   <= issue && (eop_q != pmai_pkg::OP_CLEAR);
      if (start_eng) begin
        run_q <= 1'b1;
        eop_q <= cmd_i.op;
      end else if (run_q && fin) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gk_q <= gk_d;
    pa_q <= ra;
    if (start_eng) begin
      base_q  <= base_sel;
      len_q   <= len_sel;
      ofs_q   <= '0;
      ins_q   <= 1'b0;
      e_q     <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
      if (cmd_i.op == pmai_pkg::OP_GATHER) n_q <= '0;
    end else begin
      if (issue || mg_step || sp_step) ofs_q <= ofs_q + (AW+1)'(1);
      if (pv_q) begin
        rv_q <= rd_val_q;
        if (rd_pr_q) begin
          cnt_q <= cnt_q + (AW+1)'(1);
          if (rd_val_q >= v_q) found_q <= 1'b1;
          if (eop_q == pmai_pkg::OP_GATHER) n_q <= n_q + (AW+1)'(1);
        end
      end
      if (mg_step && take) ins_q <= 1'b1;
      if (sp_step) begin
        e_q <= place ? (e_q + EW'(len_q) - EW'(n_q)) : (e_q - EW'(n_q));
      end
    end
  end

  // algorithm registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log_q <= LW'(INIT_LOG);
      count_q   <= '0;
      pass_q    <= '0;
    end else begin
      if (cmd_i.cap_inc) cap_log_q <= cap_log_q + LW'(1);
      if (cmd_i.cnt_inc) count_q <= count_q + (AW+1)'(1);
      if (cmd_i.pass_clr) begin
        pass_q <= '0;
      end else if (cmd_i.pass_inc) begin
        pass_q <= pass_q + PSW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      v_q   <= value_i;
      idx_q <= slot_index_i;
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= AW'(1) << (cap_log_q - chunk_log);
      if (count_q == '0) bnd_q <= AW'(cap - (AW+1)'(1));
    end
    if (cmd_i.srch_step) begin
      if (found_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid + AW'(1);
      end
    end
    if (cmd_i.set_bound) begin
      bnd_q <= (bnd_full >= cap) ? AW'(cap - (AW+1)'(1)) : bnd_full[AW-1:0];
    end
    if (cmd_i.lvl_init) begin
      level_q <= LW'(1);
    end else if (cmd_i.lvl_inc) begin
      level_q <= level_q + LW'(1);
    end
  end

  // result register
  logic rd_hit;
  assign rd_hit = (op_q == pmai_pkg::OPC_READ) && (IW'(idx_q) < IW'(cap)) && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.res_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_write) begin
      slot_occupied_o     <= rd_hit;
      slot_value_o        <= rd_hit ? rv_q : 32'sd0;
      element_count_o     <= 11'(count_q + (AW+1)'(cmd_i.cnt_inc));
      capacity_exponent_o <= 4'(cap_log_q);
      status_o            <= cmd_i.res_drop;
    end
  end

  assign sts_o.done     = done_q;
  assign sts_o.is_read  = (op_q == pmai_pkg::OPC_READ);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.srch_eq  = (lo_q == hi_q);
  assign sts_o.room     = (cnt_q < chunk_len);
  assign sts_o.lvl_over = (wlog > (LW+1)'(cap_log_q));
  assign sts_o.dens_ok  = (lhs < rhs);
  assign sts_o.cap_full = (cap_log_q == LW'(AW));
  assign sts_o.pass_max = (pass_q == PSW'(pmai_pkg::RETRY_LIMIT));

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_eng |-> !run_q)
    else $error("engine started while running");

  a_merge_inserted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && fin && (eop_q == pmai_pkg::OP_MERGE)) |-> ins_q)
    else $error("merge finished without placing the new value");

  a_spread_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_step && place) |-> (ofs_q < len_q))
    else $error("spread placed beyond its window");

  a_count_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap)
    else $error("element count exceeds capacity");

endmodule
`default_nettype wire

// ===== hdl/packed_memory_array_insert_core.sv =====
// Top level of the sorted gapped slot array insert core.
// Instantiates pmai_ctrl and pmai_dp; depends on pmai_pkg.
//
// A transaction is taken when start is high and busy is low; its one result appears on
// the result ports for a single cycle with done_o high, and the receiver cannot stall it.
// After reset the block sweeps the present bits of all MAX_CAPACITY slots clear with busy
// high. An insert costs one chunk sweep (at most 16 slots) per binary search step over the
// chunks, then a chunk count, gather and merge, three more chunk sweeps. A full chunk adds
// a count sweep per level window tried, then a gather and spread of the chosen window, and
// a resize gathers the whole array and spreads it over the doubled capacity; each memory
// sweep is set by the single read and write port of the slot memory.
`timescale 1ns / 1ps
`default_nettype none
module packed_memory_array_insert_core #(
  parameter int unsigned MAX_CAPACITY     = 1024,
  parameter int unsigned INITIAL_CAPACITY = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [9:0]         slot_index_i,
  output logic                    done_o,
  output logic                    slot_occupied_o,
  output logic signed [31:0]      slot_value_o,
  output logic [10:0]             element_count_o,
  output logic [3:0]              capacity_exponent_o,
  output logic                    status_o
);

  pmai_pkg::cmd_t cmd;
  pmai_pkg::sts_t sts;

  pmai_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  pmai_dp #(
    .MAX_CAPACITY     (MAX_CAPACITY),
    .INITIAL_CAPACITY (INITIAL_CAPACITY)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .opcode_i            (opcode_i),
    .value_i             (value_i),
    .slot_index_i        (slot_index_i),
    .done_o              (done_o),
    .slot_occupied_o     (slot_occupied_o),
    .slot_value_o        (slot_value_o),
    .element_count_o     (element_count_o),
    .capacity_exponent_o (capacity_exponent_o),
    .status_o            (status_o)
  );

endmodule
`default_nettype wire
